// ----- rtl/core/point_in_triangle_mesh_test_assert.svh -----
// Assertion macros shared by the point-in-triangle mesh test RTL.
`ifndef POINT_IN_TRIANGLE_MESH_TEST_ASSERT_SVH
`define POINT_IN_TRIANGLE_MESH_TEST_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define PTMT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptmt same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define PTMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptmt next-cycle check failed");

`endif

// ----- rtl/core/ptmt_pkg.sv -----
// Shared types, constants and helpers of the point-in-triangle mesh test.
package ptmt_pkg;

  // Default sizes
  localparam int MAX_TRIANGLES_DEF = 256;
  localparam int COORD_BITS_DEF    = 16;

  // Fixed field widths
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;
  localparam int OUT_DW  = 8;

  // Configuration port
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;
  localparam logic [0:0] REG_TRI_COUNT = 1'b0;

  // Item kinds carried on tuser
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } ptmt_state_t;

  // Status of the triangle test pipeline
  typedef struct packed {
    logic busy;
    logic hit;
  } ptmt_stat_t;

  // Address bits for a store of the given depth
  function automatic int addr_bits(input int depth);
    addr_bits = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ----- rtl/core/point_in_triangle_mesh_test.sv -----
// Top level of the point-in-triangle mesh test: stream ports, control and triangle store.
//
// The block keeps up to MAX_TRIANGLES triangles in one RAM word per slot. A load item
// (tuser 0) writes its three vertices into the given slot if below MAX_TRIANGLES
// and is acknowledged once the output register is free. A query item (tuser 1) tests
// its point against slots 0 to n-1, where n is triangle_count clamped to
// MAX_TRIANGLES, and reports whether any triangle holds the point. The store RAM
// delivers one triangle a cycle. One item is worked on at a time; a new item is
// accepted while an earlier result still waits on the output register. Coordinates
// are signed fixed point of COORD_BITS bits; the edge arithmetic is exact.
module point_in_triangle_mesh_test #(
  parameter int MAX_TRIANGLES = ptmt_pkg::MAX_TRIANGLES_DEF,
  parameter int COORD_BITS    = ptmt_pkg::COORD_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  // Input item stream
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // tdata from bit 0: slot, ax, ay, bx, by, cx, cy, query_x, query_y
  input  logic [ptmt_pkg::SLOT_W+8*COORD_BITS-1:0]     in_tdata,
  // tuser: mode
  input  logic                                         in_tuser,
  // Result stream
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // tdata from bit 0: inside_res, zero padding
  output logic [ptmt_pkg::OUT_DW-1:0]                  out_tdata,
  // tuser: was_query
  output logic                                         out_tuser,
  // Configuration port
  input  logic                                         cfg_psel,
  input  logic                                         cfg_penable,
  input  logic                                         cfg_pwrite,
  input  logic [ptmt_pkg::CFG_AW-1:0]                  cfg_paddr,
  input  logic [ptmt_pkg::CFG_DW-1:0]                  cfg_pwdata,
  output logic [ptmt_pkg::CFG_DW-1:0]                  cfg_prdata,
  output logic                                         cfg_pready
);
  import ptmt_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int AW = addr_bits(MAX_TRIANGLES);
  localparam int NW = $clog2(MAX_TRIANGLES + 1);
  localparam int WW = 6 * CB;

  ptmt_state_t state_r, state_nxt;
  logic [NW-1:0] idx_r, idx_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [NW-1:0] n_in;
  logic          pend_query_r, pend_query_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic          out_query_r;
  logic          out_inside_r;
  logic [COUNT_W-1:0] triangle_count_r;

  logic signed [CB-1:0] px_r, py_r;
  logic [SLOT_W-1:0]    in_slot;
  logic                 in_acc;
  logic                 slot_ok;
  logic                 out_free;
  logic                 cfg_wr;
  logic                 start;
  logic                 issue;
  logic                 ram_we;
  logic [WW-1:0]        ram_rdata;
  ptmt_stat_t           stat;

  // Input decode
  assign in_acc   = in_tvalid && in_tready;
  assign in_slot  = in_tdata[SLOT_W-1:0];
  assign slot_ok  = 32'(in_slot) < 32'(MAX_TRIANGLES);
  assign out_free = !out_tvalid_r || out_tready;

  // Clamp the triangle count to the store depth
  always_comb begin
    if (32'(triangle_count_r) > 32'(MAX_TRIANGLES)) begin
      n_in = NW'(MAX_TRIANGLES);
    end else begin
      n_in = NW'(triangle_count_r);
    end
  end

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_TRI_COUNT) ?
                      CFG_DW'(triangle_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      triangle_count_r <= '0;
    end else if (cfg_wr && (cfg_paddr[CFG_AW-1:2] == REG_TRI_COUNT)) begin
      triangle_count_r <= cfg_pwdata[COUNT_W-1:0];
    end
  end

  // Control: next state and outputs
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    pend_query_nxt = pend_query_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    start          = 1'b0;
    issue          = 1'b0;
    ram_we         = 1'b0;
    in_tready      = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == MODE_QUERY) begin
            start          = 1'b1;
            idx_nxt        = '0;
            n_nxt          = n_in;
            pend_query_nxt = 1'b1;
            state_nxt      = (n_in == '0) ? ST_DONE : ST_RUN;
          end else begin
            ram_we         = slot_ok;
            pend_query_nxt = 1'b0;
            state_nxt      = ST_DONE;
          end
        end
      end
      ST_RUN: begin
        issue   = 1'b1;
        idx_nxt = idx_r + NW'(1);
        if (idx_r + NW'(1) == n_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      n_r          <= '0;
      pend_query_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      n_r          <= n_nxt;
      pend_query_r <= pend_query_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Hold the query point
  always_ff @(posedge clk) begin
    if (start) begin
      px_r <= in_tdata[SLOT_W+WW +: CB];
      py_r <= in_tdata[SLOT_W+WW+CB +: CB];
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_query_r  <= pend_query_r;
      out_inside_r <= pend_query_r && stat.hit;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_query_r;
  assign out_tdata  = OUT_DW'(out_inside_r);

  // Triangle store: vertices a, b, c packed from the lowest bits up
  ptmt_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_TRIANGLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_slot)),
    .wdata (in_tdata[SLOT_W +: WW]),
    .re    (issue),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Edge-sign test pipeline
  ptmt_tri_test #(
    .COORD_BITS (COORD_BITS)
  ) u_tri_test (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .issue (issue),
    .px    (px_r),
    .py    (py_r),
    .word  (ram_rdata),
    .stat  (stat)
  );

`include "point_in_triangle_mesh_test_assert.svh"

  // The store is never read and written in the same cycle
  `PTMT_ASSERT_NOW(a_no_rw_overlap, ram_we, !issue)
  // The read index stays inside the clamped count
  `PTMT_ASSERT_NOW(a_idx_in_range, state_r == ST_RUN, idx_r < n_r)
  // A drained pipeline hands over to the result stage
  `PTMT_ASSERT_NEXT(a_drain_done, state_r == ST_DRAIN && !stat.busy, state_r == ST_DONE)
  // A load acknowledgment never reports a hit
  `PTMT_ASSERT_NOW(a_load_no_hit, out_tvalid && !out_tuser, out_tdata == '0)

endmodule

// ----- rtl/core/ptmt_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ptmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = ptmt_pkg::addr_bits(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/ptmt_tri_test.sv -----
// Three-stage edge-sign pipeline that tests a point against one triangle a cycle.
module ptmt_tri_test #(
  parameter int COORD_BITS = ptmt_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          issue,
  input  logic signed [COORD_BITS-1:0]  px,
  input  logic signed [COORD_BITS-1:0]  py,
  input  logic [6*COORD_BITS-1:0]       word,
  output ptmt_pkg::ptmt_stat_t          stat
);
  import ptmt_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int PW = 2 * CB + 2;

  logic v0_r, v1_r, v2_r;
  logic hit_r;

  logic signed [CB-1:0] vx [3];
  logic signed [CB-1:0] vy [3];

  logic signed [CB:0]   d_px_r [3];
  logic signed [CB:0]   d_qy_r [3];
  logic signed [CB:0]   d_qx_r [3];
  logic signed [CB:0]   d_py_r [3];
  logic signed [PW-1:0] lhs_r  [3];
  logic signed [PW-1:0] rhs_r  [3];
  logic [2:0]           neg;
  logic                 tri_hit;

  // Unpack vertices: a, b, c from the lowest bits up, x below y
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vx[k] = word[2*k*CB +: CB];
      vy[k] = word[(2*k+1)*CB +: CB];
    end
  end

  // One lane per directed edge (point, q1, q2)
  for (genvar k = 0; k < 3; k++) begin : g_edge
    localparam int Q2 = (k == 2) ? 0 : k + 1;

    // Stage 1: differences, one bit wider than the coordinates
    always_ff @(posedge clk) begin
      if (v0_r) begin
        d_px_r[k] <= {px[CB-1], px} - {vx[Q2][CB-1], vx[Q2]};
        d_qy_r[k] <= {vy[k][CB-1], vy[k]} - {vy[Q2][CB-1], vy[Q2]};
        d_qx_r[k] <= {vx[k][CB-1], vx[k]} - {vx[Q2][CB-1], vx[Q2]};
        d_py_r[k] <= {py[CB-1], py} - {vy[Q2][CB-1], vy[Q2]};
      end
    end

    // Stage 2: exact cross products
    always_ff @(posedge clk) begin
      if (v1_r) begin
        lhs_r[k] <= d_px_r[k] * d_qy_r[k];
        rhs_r[k] <= d_qx_r[k] * d_py_r[k];
      end
    end

    // Stage 3: edge flag, sign strictly below zero
    assign neg[k] = lhs_r[k] < rhs_r[k];
  end

  // Inside when all three flags agree, degenerate triangles included
  assign tri_hit = (neg[0] == neg[1]) && (neg[1] == neg[2]);

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // Accumulate the hit over all tested triangles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (start) begin
      hit_r <= 1'b0;
    end else if (v2_r && tri_hit) begin
      hit_r <= 1'b1;
    end
  end

  assign stat.busy = v0_r | v1_r | v2_r;
  assign stat.hit  = hit_r;

endmodule
